// File: design/bu2x_pkg.sv
// Shared types and constants for the 2x bilinear upsampler.
package bu2x_pkg;

  localparam int CH_W     = 8;
  localparam int NUM_CH   = 3;
  localparam int OUT_W    = 11;
  localparam int CFG_W    = 11;
  localparam int CFG_IDX_W = 2;
  localparam int BLOCK_N  = 4;
  localparam int BLK_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAY_MODE    = 2'd2;

  localparam logic [CFG_W-1:0] DIM_RESET = 11'd1024;
  localparam logic [BLK_IDX_W-1:0] BLK_LAST_IDX = 2'd3;

  typedef logic [NUM_CH-1:0][CH_W-1:0] pixel_t;

  typedef struct packed {
    logic [CH_W-1:0] chan_zero;
    logic [CH_W-1:0] chan_one;
    logic [CH_W-1:0] chan_two;
    logic            frame_start;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] out_row;
    logic [OUT_W-1:0] out_col;
    logic [CH_W-1:0]  res_zero;
    logic [CH_W-1:0]  res_one;
    logic [CH_W-1:0]  res_two;
    logic             block_last;
  } out_item_t;

  typedef struct packed {
    logic [CH_W-1:0] copy;
    logic [CH_W-1:0] vmean;
    logic [CH_W-1:0] hmean;
    logic [CH_W-1:0] qmean;
  } lane_out_t;

endpackage

// File: design/bilinear_upsample_2x.sv
// Top level of the 2x bilinear upsampler: position tracking, line store, lanes, merge.
// A block's results come from stage 1 via the merge stage's block register.
// Each pixel that yields a block gives four output pixels, sent one pixel per cycle
// while out_stall is low; pixels on row 0 or column 0 yield no block.
// Reset: synchronous active-low; clears position, neighbor pixels and config.
// The line store is not cleared; there is no clearing pass after reset.
module bilinear_upsample_2x #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  bu2x_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output bu2x_pkg::out_item_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bu2x_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bu2x_pkg::CFG_W-1:0]         cfg_data
);

  localparam int CW  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW  = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WCW = (bu2x_pkg::CFG_W > $clog2(MAX_WIDTH + 1)) ?
                       bu2x_pkg::CFG_W : $clog2(MAX_WIDTH + 1);
  localparam int HCW = (bu2x_pkg::CFG_W > $clog2(MAX_HEIGHT + 1)) ?
                       bu2x_pkg::CFG_W : $clog2(MAX_HEIGHT + 1);
  localparam int PIX_W = bu2x_pkg::NUM_CH * bu2x_pkg::CH_W;

  logic [bu2x_pkg::CFG_W-1:0] width_r;
  logic [bu2x_pkg::CFG_W-1:0] height_r;
  logic                       gray_r;

  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [CW-1:0] col_nxt;
  logic [RW-1:0] row_nxt;

  logic          s1_valid_r;
  bu2x_pkg::pixel_t s1_cur_r;
  logic [CW-1:0] s1_col_r;
  logic [RW-1:0] s1_row_r;
  logic          s1_emit_r;
  logic          s1_byp_r;
  bu2x_pkg::pixel_t s1_byp_pix_r;

  bu2x_pkg::pixel_t left_r;
  bu2x_pkg::pixel_t above_left_r;

  logic [WCW-1:0] w_eff;
  logic [HCW-1:0] h_eff;
  logic [WCW-1:0] c0;
  logic [WCW-1:0] c1;
  logic [WCW-1:0] cn;
  logic [HCW-1:0] r0;
  logic [HCW-1:0] r1;
  logic [HCW-1:0] r2;
  logic [HCW-1:0] rn;
  logic           emit;
  bu2x_pkg::pixel_t cur;

  logic             accept;
  logic             s1_move;
  logic             seq_free;
  logic [PIX_W-1:0] ram_rdata;
  bu2x_pkg::pixel_t above;
  bu2x_pkg::lane_out_t [bu2x_pkg::NUM_CH-1:0] lanes;
  logic [bu2x_pkg::OUT_W-1:0] base_row;
  logic [bu2x_pkg::OUT_W-1:0] base_col;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bu2x_pkg::DIM_RESET;
      height_r <= bu2x_pkg::DIM_RESET;
      gray_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bu2x_pkg::CFG_FRAME_WIDTH:  width_r  <= cfg_data;
        bu2x_pkg::CFG_FRAME_HEIGHT: height_r <= cfg_data;
        bu2x_pkg::CFG_GRAY_MODE:    gray_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (WCW'(width_r) < WCW'(2)) w_eff = WCW'(2);
    else if (WCW'(width_r) > WCW'(MAX_WIDTH)) w_eff = WCW'(MAX_WIDTH);
    else w_eff = WCW'(width_r);
    priority if (HCW'(height_r) < HCW'(2)) h_eff = HCW'(2);
    else if (HCW'(height_r) > HCW'(MAX_HEIGHT)) h_eff = HCW'(MAX_HEIGHT);
    else h_eff = HCW'(height_r);
  end

  always_comb begin
    c0 = in_data.frame_start ? '0 : WCW'(col_r);
    r0 = in_data.frame_start ? '0 : HCW'(row_r);
    r1 = (r0 >= h_eff) ? '0 : r0;
    if (c0 >= w_eff) begin
      c1 = '0;
      r2 = ((r1 + 1'b1) >= h_eff) ? '0 : r1 + 1'b1;
    end else begin
      c1 = c0;
      r2 = r1;
    end
    emit = (r2 != '0) && (c1 != '0);
    cn   = c1 + 1'b1;
    if (cn >= w_eff) begin
      col_nxt = '0;
      rn      = ((r2 + 1'b1) >= h_eff) ? '0 : r2 + 1'b1;
    end else begin
      col_nxt = CW'(cn);
      rn      = r2;
    end
    row_nxt = RW'(rn);
  end

  always_comb begin
    cur[0] = in_data.chan_zero;
    cur[1] = gray_r ? '0 : in_data.chan_one;
    cur[2] = gray_r ? '0 : in_data.chan_two;
  end

  assign s1_move  = s1_valid_r && seq_free;
  assign in_stall = s1_valid_r && !seq_free;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      row_r        <= '0;
      s1_valid_r   <= 1'b0;
      left_r       <= '0;
      above_left_r <= '0;
    end else begin
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        left_r       <= s1_cur_r;
        above_left_r <= above;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cur_r     <= cur;
      s1_col_r     <= CW'(c1);
      s1_row_r     <= RW'(r2);
      s1_emit_r    <= emit;
      s1_byp_r     <= s1_move && (s1_col_r == CW'(c1));
      s1_byp_pix_r <= s1_cur_r;
    end
  end

  bu2x_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk  (clk),
    .we   (s1_move),
    .waddr(s1_col_r),
    .wdata(s1_cur_r),
    .re   (accept),
    .raddr(CW'(c1)),
    .rdata(ram_rdata)
  );

  assign above = s1_byp_r ? s1_byp_pix_r : bu2x_pkg::pixel_t'(ram_rdata);

  for (genvar k = 0; k < bu2x_pkg::NUM_CH; k++) begin : g_lane
    bu2x_lane u_lane (
      .p  (above_left_r[k]),
      .b  (left_r[k]),
      .r  (above[k]),
      .d  (s1_cur_r[k]),
      .res(lanes[k])
    );
  end

  assign base_row = bu2x_pkg::OUT_W'({s1_row_r - 1'b1, 1'b0});
  assign base_col = bu2x_pkg::OUT_W'({s1_col_r - 1'b1, 1'b0});

  bu2x_out_seq u_out_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (s1_move && s1_emit_r),
    .lanes    (lanes),
    .base_row (base_row),
    .base_col (base_col),
    .free     (seq_free),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("input stalled with empty stage");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r)
    else $error("accepted transaction lost");

  a_block_boundary: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_data.block_last) |=>
      !(out_valid && out_data.block_last))
    else $error("block end repeated");

endmodule

// File: design/bu2x_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bu2x_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/bu2x_lane.sv
// One channel lane: copy, vertical, horizontal and four-pixel means.
module bu2x_lane (
  input  logic [bu2x_pkg::CH_W-1:0] p,
  input  logic [bu2x_pkg::CH_W-1:0] b,
  input  logic [bu2x_pkg::CH_W-1:0] r,
  input  logic [bu2x_pkg::CH_W-1:0] d,
  output bu2x_pkg::lane_out_t       res
);

  logic [bu2x_pkg::CH_W:0]   sum_pb;
  logic [bu2x_pkg::CH_W:0]   sum_pr;
  logic [bu2x_pkg::CH_W:0]   sum_rd;
  logic [bu2x_pkg::CH_W+1:0] sum_all;

  assign sum_pb  = {1'b0, p} + {1'b0, b};
  assign sum_pr  = {1'b0, p} + {1'b0, r};
  assign sum_rd  = {1'b0, r} + {1'b0, d};
  assign sum_all = {1'b0, sum_pb} + {1'b0, sum_rd};

  assign res.copy  = p;
  assign res.vmean = sum_pb[bu2x_pkg::CH_W:1];
  assign res.hmean = sum_pr[bu2x_pkg::CH_W:1];
  assign res.qmean = sum_all[bu2x_pkg::CH_W+1:2];

endmodule

// File: design/bu2x_out_seq.sv
// Merge stage: builds the 2x2 block from the lanes and sends it one pixel a cycle while out_stall is low.
module bu2x_out_seq (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   load,
  input  bu2x_pkg::lane_out_t [bu2x_pkg::NUM_CH-1:0] lanes,
  input  logic [bu2x_pkg::OUT_W-1:0]             base_row,
  input  logic [bu2x_pkg::OUT_W-1:0]             base_col,
  output logic                                   free,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output bu2x_pkg::out_item_t                    out_data
);

  bu2x_pkg::out_item_t              blk_r [bu2x_pkg::BLOCK_N];
  bu2x_pkg::out_item_t              blk_nxt [bu2x_pkg::BLOCK_N];
  logic [bu2x_pkg::BLK_IDX_W-1:0]   idx_r;
  logic                             busy_r;
  logic [bu2x_pkg::OUT_W-1:0]       row_odd;
  logic [bu2x_pkg::OUT_W-1:0]       col_odd;

  assign row_odd = base_row + bu2x_pkg::OUT_W'(1);
  assign col_odd = base_col + bu2x_pkg::OUT_W'(1);

  always_comb begin
    blk_nxt[0] = '{out_row: base_row, out_col: base_col,
                   res_zero: lanes[0].copy, res_one: lanes[1].copy,
                   res_two: lanes[2].copy, block_last: 1'b0};
    blk_nxt[1] = '{out_row: row_odd, out_col: base_col,
                   res_zero: lanes[0].vmean, res_one: lanes[1].vmean,
                   res_two: lanes[2].vmean, block_last: 1'b0};
    blk_nxt[2] = '{out_row: base_row, out_col: col_odd,
                   res_zero: lanes[0].hmean, res_one: lanes[1].hmean,
                   res_two: lanes[2].hmean, block_last: 1'b0};
    blk_nxt[3] = '{out_row: row_odd, out_col: col_odd,
                   res_zero: lanes[0].qmean, res_one: lanes[1].qmean,
                   res_two: lanes[2].qmean, block_last: 1'b1};
  end

  assign free      = !busy_r || (idx_r == bu2x_pkg::BLK_LAST_IDX && !out_stall);
  assign out_valid = busy_r;
  assign out_data  = blk_r[idx_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (load && free) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (busy_r && !out_stall) begin
      if (idx_r == bu2x_pkg::BLK_LAST_IDX) begin
        busy_r <= 1'b0;
      end
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      for (int k = 0; k < bu2x_pkg::BLOCK_N; k++) begin
        blk_r[k] <= blk_nxt[k];
      end
    end
  end

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for bilinear_upsample_2x: directed table, random frames, size extremes.
`timescale 1ns / 1ps
module tb_top;

  localparam int MAX_DIM    = 1024;
  localparam int WATCHDOG   = 5000;
  localparam int DRAIN_GAP  = 8;
  localparam int MAX_LOGGED = 50;

  typedef enum logic {ROW_PIXEL, ROW_REG} row_kind_t;

  // typed rows expect a flat block of value v at the image origin
  typedef struct {
    row_kind_t                      kind;
    logic [bu2x_pkg::CFG_IDX_W-1:0] idx;
    logic [bu2x_pkg::CFG_W-1:0]     val;
    bu2x_pkg::in_item_t             px;
    bit                             typed;
    logic [bu2x_pkg::CH_W-1:0]      v;
  } stim_row_t;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  bu2x_pkg::in_item_t             in_data   = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  bu2x_pkg::out_item_t            out_data;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [bu2x_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bu2x_pkg::CFG_W-1:0]     cfg_data  = '0;

  int send_idle   = 0;
  int recv_idle   = 0;
  int fail_cnt    = 0;
  int idle_cycles = 0;

  // upsampler state as the testbench sees it
  bu2x_pkg::pixel_t           line_mem [MAX_DIM];
  bit                         line_mem_ok [MAX_DIM];
  bu2x_pkg::pixel_t           left_px   = '0;
  bu2x_pkg::pixel_t           upleft_px = '0;
  int unsigned                pos_row   = 0;
  int unsigned                pos_col   = 0;
  logic [bu2x_pkg::CFG_W-1:0] reg_width  = bu2x_pkg::DIM_RESET;
  logic [bu2x_pkg::CFG_W-1:0] reg_height = bu2x_pkg::DIM_RESET;
  logic                       reg_gray   = 1'b0;

  bu2x_pkg::out_item_t due_pixels [$];
  bu2x_pkg::out_item_t blk [bu2x_pkg::BLOCK_N];
  int                  blk_cnt;
  stim_row_t           stim_tbl [$];
  stim_row_t           pending_regs [$];

  bilinear_upsample_2x u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int unsigned clamp_dim(input logic [bu2x_pkg::CFG_W-1:0] v);
    if (v < 2) return 2;
    if (v > MAX_DIM) return MAX_DIM;
    return 32'(v);
  endfunction

  function automatic void wrap_pos(inout int unsigned r, inout int unsigned c);
    if (c >= clamp_dim(reg_width)) begin
      c = 0;
      r++;
      if (r >= clamp_dim(reg_height)) r = 0;
    end
  endfunction

  // position a pixel lands at, given the current state
  function automatic void land(input logic fs, output int unsigned r, output int unsigned c);
    r = fs ? 0 : pos_row;
    c = fs ? 0 : pos_col;
    if (r >= clamp_dim(reg_height)) r = 0;
    wrap_pos(r, c);
  endfunction

  task automatic upsample_step(input bu2x_pkg::in_item_t px);
    bu2x_pkg::pixel_t cur;
    bu2x_pkg::pixel_t above;
    bu2x_pkg::pixel_t val [bu2x_pkg::BLOCK_N];
    int unsigned      r, c, orow, ocol;
    int               p, b, a, d, t;
    cur[0] = px.chan_zero;
    cur[1] = reg_gray ? '0 : px.chan_one;
    cur[2] = reg_gray ? '0 : px.chan_two;
    land(px.frame_start, r, c);
    above = line_mem_ok[c] ? line_mem[c] : '0;
    blk_cnt = 0;
    if (r >= 1 && c >= 1) begin
      for (int k = 0; k < bu2x_pkg::NUM_CH; k++) begin
        p = int'(upleft_px[k]);
        b = int'(left_px[k]);
        a = int'(above[k]);
        d = int'(cur[k]);
        val[0][k] = upleft_px[k];
        t = (p + b) >> 1;
        val[1][k] = t[bu2x_pkg::CH_W-1:0];
        t = (p + a) >> 1;
        val[2][k] = t[bu2x_pkg::CH_W-1:0];
        t = (p + b + a + d) >> 2;
        val[3][k] = t[bu2x_pkg::CH_W-1:0];
      end
      orow = 2 * (r - 1);
      ocol = 2 * (c - 1);
      for (int i = 0; i < bu2x_pkg::BLOCK_N; i++) begin
        blk[i].out_row    = bu2x_pkg::OUT_W'(orow + (i % 2));
        blk[i].out_col    = bu2x_pkg::OUT_W'(ocol + (i / 2));
        blk[i].res_zero   = val[i][0];
        blk[i].res_one    = val[i][1];
        blk[i].res_two    = val[i][2];
        blk[i].block_last = (i == bu2x_pkg::BLK_LAST_IDX);
      end
      blk_cnt = bu2x_pkg::BLOCK_N;
    end
    upleft_px      = above;
    left_px        = cur;
    line_mem[c]    = cur;
    line_mem_ok[c] = 1'b1;
    c++;
    wrap_pos(r, c);
    pos_row = r;
    pos_col = c;
  endtask

  function automatic bu2x_pkg::out_item_t flat_px(input int r, input int c,
                                                  input logic [bu2x_pkg::CH_W-1:0] v,
                                                  input logic last);
    bu2x_pkg::out_item_t o;
    o.out_row    = bu2x_pkg::OUT_W'(r);
    o.out_col    = bu2x_pkg::OUT_W'(c);
    o.res_zero   = v;
    o.res_one    = reg_gray ? '0 : v;
    o.res_two    = reg_gray ? '0 : v;
    o.block_last = last;
    return o;
  endfunction

  function automatic bu2x_pkg::in_item_t pix(input int a, input int b, input int c,
                                             input bit fs);
    bu2x_pkg::in_item_t px;
    px.chan_zero   = bu2x_pkg::CH_W'(a);
    px.chan_one    = bu2x_pkg::CH_W'(b);
    px.chan_two    = bu2x_pkg::CH_W'(c);
    px.frame_start = fs;
    return px;
  endfunction

  function automatic stim_row_t reg_row(input logic [bu2x_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [bu2x_pkg::CFG_W-1:0] val);
    stim_row_t row;
    row.kind  = ROW_REG;
    row.idx   = idx;
    row.val   = val;
    row.px    = '0;
    row.typed = 1'b0;
    row.v     = '0;
    return row;
  endfunction

  function automatic stim_row_t px_row(input bu2x_pkg::in_item_t px, input bit typed,
                                       input logic [bu2x_pkg::CH_W-1:0] v);
    stim_row_t row;
    row       = reg_row('0, '0);
    row.kind  = ROW_PIXEL;
    row.px    = px;
    row.typed = typed;
    row.v     = v;
    return row;
  endfunction

  function automatic void add_px(input bu2x_pkg::in_item_t px);
    stim_tbl.push_back(px_row(px, 1'b0, '0));
  endfunction

  function automatic void add_chk(input bu2x_pkg::in_item_t px,
                                  input logic [bu2x_pkg::CH_W-1:0] v);
    stim_tbl.push_back(px_row(px, 1'b1, v));
  endfunction

  function automatic void add_reg(input logic [bu2x_pkg::CFG_IDX_W-1:0] idx, input int val);
    stim_tbl.push_back(reg_row(idx, bu2x_pkg::CFG_W'(val)));
  endfunction

  function automatic logic [bu2x_pkg::CH_W-1:0] rand_chan();
    unique case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return bu2x_pkg::CH_W'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [bu2x_pkg::CFG_W-1:0] pick_dim(input int unsigned top);
    unique case ($urandom_range(11))
      0: return bu2x_pkg::CFG_W'(0);
      1: return bu2x_pkg::CFG_W'(1);
      2: return bu2x_pkg::CFG_W'(2047);
      3: return bu2x_pkg::CFG_W'(MAX_DIM);
      default: return bu2x_pkg::CFG_W'($urandom_range(top, 2));
    endcase
  endfunction

  task automatic report(input string what, input int got, input int want);
    if (fail_cnt < MAX_LOGGED)
      $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
    fail_cnt++;
  endtask

  task automatic check_pixel(input bu2x_pkg::out_item_t got);
    bu2x_pkg::out_item_t want;
    if (due_pixels.size() == 0) begin
      report("unexpected transaction, out_row", int'(got.out_row), -1);
      return;
    end
    want = due_pixels.pop_front();
    if (got.out_row !== want.out_row)
      report("out_row", int'(got.out_row), int'(want.out_row));
    if (got.out_col !== want.out_col)
      report("out_col", int'(got.out_col), int'(want.out_col));
    if (got.res_zero !== want.res_zero)
      report("res_zero", int'(got.res_zero), int'(want.res_zero));
    if (got.res_one !== want.res_one)
      report("res_one", int'(got.res_one), int'(want.res_one));
    if (got.res_two !== want.res_two)
      report("res_two", int'(got.res_two), int'(want.res_two));
    if (got.block_last !== want.block_last)
      report("block_last", int'(got.block_last), int'(want.block_last));
  endtask

  task automatic send_pixel(input stim_row_t row);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= row.px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    upsample_step(row.px);
    if (row.typed) begin
      due_pixels.push_back(flat_px(0, 0, row.v, 1'b0));
      due_pixels.push_back(flat_px(1, 0, row.v, 1'b0));
      due_pixels.push_back(flat_px(0, 1, row.v, 1'b0));
      due_pixels.push_back(flat_px(1, 1, row.v, 1'b1));
    end else begin
      for (int i = 0; i < blk_cnt; i++) due_pixels.push_back(blk[i]);
    end
  endtask

  // all results in, then a DRAIN_GAP wait for pixels that produce none
  task automatic settle();
    in_valid <= 1'b0;
    while (due_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic write_regs();
    stim_row_t w;
    settle();
    while (pending_regs.size() != 0) begin
      w = pending_regs.pop_front();
      cfg_valid <= 1'b1;
      cfg_index <= w.idx;
      cfg_data  <= w.val;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      unique case (w.idx)
        bu2x_pkg::CFG_FRAME_WIDTH:  reg_width  = w.val;
        bu2x_pkg::CFG_FRAME_HEIGHT: reg_height = w.val;
        bu2x_pkg::CFG_GRAY_MODE:    reg_gray   = w.val[0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_frames(input logic [bu2x_pkg::CFG_W-1:0] w,
                            input logic [bu2x_pkg::CFG_W-1:0] h,
                            input logic g, input int n_px);
    bu2x_pkg::in_item_t px;
    int unsigned        r, c;
    pending_regs.push_back(reg_row(bu2x_pkg::CFG_FRAME_WIDTH, w));
    pending_regs.push_back(reg_row(bu2x_pkg::CFG_FRAME_HEIGHT, h));
    pending_regs.push_back(reg_row(bu2x_pkg::CFG_GRAY_MODE, bu2x_pkg::CFG_W'(g)));
    write_regs();
    for (int i = 0; i < n_px; i++) begin
      px = pix(rand_chan(), rand_chan(), rand_chan(), 1'b0);
      if (i == 0) px.frame_start = ($urandom_range(3) != 0);
      else px.frame_start = ($urandom_range(39) == 0);
      // never let a lower row read a line-store column that was never filled
      land(px.frame_start, r, c);
      if (r >= 1 && !line_mem_ok[c]) px.frame_start = 1'b1;
      send_pixel(px_row(px, 1'b0, '0));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_pixel(out_data);
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("bilinear_upsample_2x test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    // reset sizes: first row only, nothing comes out
    add_px(pix(255, 255, 255, 1));
    add_px(pix(0, 0, 0, 0));
    add_px(pix(17, 34, 51, 0));
    // narrowing past the current column wraps to the next row
    add_reg(bu2x_pkg::CFG_FRAME_WIDTH, 2);
    add_px(pix(255, 0, 255, 0));
    add_px(pix(1, 2, 3, 0));
    add_reg(bu2x_pkg::CFG_FRAME_HEIGHT, 2);
    add_px(pix(255, 255, 255, 1));
    add_px(pix(255, 255, 255, 0));
    add_px(pix(255, 255, 255, 0));
    add_chk(pix(255, 255, 255, 0), 8'd255);
    // next frame by row wrap alone
    add_px(pix(0, 0, 0, 0));
    add_px(pix(0, 0, 0, 0));
    add_px(pix(0, 0, 0, 0));
    add_chk(pix(0, 0, 0, 0), 8'd0);
    add_px(pix(255, 0, 1, 1));
    add_px(pix(0, 255, 0, 0));
    add_px(pix(254, 1, 255, 0));
    add_px(pix(1, 254, 255, 0));
    add_reg(bu2x_pkg::CFG_GRAY_MODE, 1);
    add_px(pix(200, 255, 255, 1));
    add_px(pix(200, 255, 255, 0));
    add_px(pix(200, 255, 255, 0));
    add_chk(pix(200, 255, 255, 0), 8'd200);
    // sizes below the minimum clamp up
    add_reg(bu2x_pkg::CFG_GRAY_MODE, 0);
    add_reg(bu2x_pkg::CFG_FRAME_WIDTH, 0);
    add_reg(bu2x_pkg::CFG_FRAME_HEIGHT, 1);
    add_px(pix(9, 255, 0, 1));
    add_px(pix(0, 128, 255, 0));
    add_px(pix(255, 255, 255, 0));
    add_px(pix(3, 3, 3, 0));

    send_idle = 38;
    recv_idle = 79;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_tbl[i]) begin
      if (stim_tbl[i].kind == ROW_REG) begin
        pending_regs.push_back(stim_tbl[i]);
      end else begin
        if (pending_regs.size() != 0) write_regs();
        send_pixel(stim_tbl[i]);
      end
    end

    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin
        send_idle = 79;
        recv_idle = 38;
      end
      if (ph == 8) begin
        send_idle = 0;
        recv_idle = 0;
      end
      run_frames(pick_dim(8), pick_dim(5), 1'($urandom_range(1)), $urandom_range(45, 25));
    end

    settle();
    if (fail_cnt == 0) begin
      $display("bilinear_upsample_2x test passed");
    end else begin
      $display("bilinear_upsample_2x test failed");
    end
    $finish;
  end

endmodule
